/* design/brfbp_pkg.sv */
// Package for the circular byte FIFO with block push and burst pop.
// Holds field widths, default sizes, status codes, the sequencer states
// and the request struct to the byte store. No dependencies.
`timescale 1ns / 1ps

package brfbp_pkg;

    // Fixed field widths of the request and result channels
    localparam int BYTE_W = 8;
    localparam int BLEN_W = 11;
    localparam int PMAX_W = 7;
    localparam int OCC_W  = 11;
    localparam int STAT_W = 2;

    // Default sizes
    localparam int DEF_CAPACITY  = 1024;
    localparam int DEF_MAX_BURST = 64;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_DATA   = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_ACCEPT = 2'd2,
        STAT_REJECT = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } t_state;

    // Access request to the byte store
    typedef struct packed {
        logic              wr_en;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
    } t_store_req;

endpackage

/* design/brfbp_store.sv */
// Byte store of the FIFO: one synchronous memory with registered read data,
// plus the write and read positions that wrap at the capacity.
// Depends on brfbp_pkg.
`timescale 1ns / 1ps

module brfbp_store
    import brfbp_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_req        i_req,
    output logic [BYTE_W-1:0] o_rd_data
);

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(CAPACITY - 1);

    logic [BYTE_W-1:0] r_mem [CAPACITY];
    logic [BYTE_W-1:0] r_rd_data;
    logic [PW-1:0]     r_wr_pos, n_wr_pos;
    logic [PW-1:0]     r_rd_pos, n_rd_pos;

    // Advance positions with wrap at the last entry
    always_comb begin
        n_wr_pos = r_wr_pos;
        n_rd_pos = r_rd_pos;
        if (i_req.wr_en) begin
            n_wr_pos = (r_wr_pos == LAST_POS) ? '0 : r_wr_pos + PW'(1);
        end
        if (i_req.rd_en) begin
            n_rd_pos = (r_rd_pos == LAST_POS) ? '0 : r_rd_pos + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_rd_pos <= '0;
        end else begin
            r_wr_pos <= n_wr_pos;
            r_rd_pos <= n_rd_pos;
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[r_wr_pos] <= i_req.wr_data;
        end
    end

    // Read port, data registered; holds between reads
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[r_rd_pos];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/byte_ring_fifo_block_push_unit.sv */
// Top level of the circular byte FIFO with all-or-nothing block push and
// bounded burst pop. Depends on brfbp_pkg and brfbp_store.
//
//  Channel   Direction  Handshake          Payload
//  request   in         i_valid / o_ready  i_req_type i_push_byte i_block_len i_pop_max
//  result    out        o_valid / i_ready  o_pop_byte o_status o_last o_occupancy
//
// A stream of push bytes runs one per cycle while the result register is free.
// A pop takes no new request until its burst ends: one read issue per cycle
// on the single memory read port while results drain, read data registered.
// A stalled result register holds the burst; reads stop until it drains.
// Synchronous active-low reset clears positions, fill and block state;
// memory contents are not cleared, and no entry is read before it is written.
`timescale 1ns / 1ps

module byte_ring_fifo_block_push_unit
    import brfbp_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int MAX_BURST = DEF_MAX_BURST
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_req_type,
    input  logic [BYTE_W-1:0] i_push_byte,
    input  logic [BLEN_W-1:0] i_block_len,
    input  logic [PMAX_W-1:0] i_pop_max,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_pop_byte,
    output logic [STAT_W-1:0] o_status,
    output logic              o_last,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int BW = $clog2(MAX_BURST + 1);
    localparam int SW = ((FW > BLEN_W) ? FW : BLEN_W) + 1;
    localparam int CW = (FW > PMAX_W) ? FW : PMAX_W;

    t_state            r_state, n_state;
    logic [FW-1:0]     r_fill, n_fill;
    logic [BLEN_W-1:0] r_block_left, n_block_left;
    logic              r_dropping, n_dropping;
    logic [BW-1:0]     r_issue_left, n_issue_left;
    logic [BW-1:0]     r_xfer_left, n_xfer_left;
    logic              r_rd_pend, n_rd_pend;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    t_status           r_out_status, n_out_status;
    logic              r_out_last, n_out_last;
    logic [OCC_W-1:0]  r_out_occ, n_out_occ;

    logic              in_acc;
    logic              out_free;
    logic              xfer;
    logic              issue;
    logic              load_res;
    t_status           res_status;
    logic [FW-1:0]     res_fill;
    logic              starting;
    logic              drop;
    logic [BLEN_W-1:0] left_now;
    logic [BLEN_W-1:0] left_after;
    logic              do_write;
    logic [PMAX_W-1:0] pmax_c;
    logic [CW-1:0]     fill_cw, pmax_cw;
    logic [BW-1:0]     pop_n;
    t_store_req        store_req;
    logic [BYTE_W-1:0] rd_data;

    brfbp_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    // Handshake outputs of the sequencer
    always_comb begin
        out_free = !r_out_valid || i_ready;
        unique case (r_state)
            S_IDLE:  o_ready = out_free;
            S_POP:   o_ready = 1'b0;
            default: o_ready = 1'b0;
        endcase
    end

    assign in_acc = i_valid && o_ready;

    // Move pending read data into the result register; issue the next read
    assign xfer  = r_rd_pend && out_free;
    assign issue = (r_state == S_POP) && (r_issue_left != '0) && (!r_rd_pend || xfer);

    // Push bookkeeping: length check on the first byte of a block
    always_comb begin
        starting   = (r_block_left == '0);
        drop       = starting ? (SW'(r_fill) + SW'(i_block_len) > SW'(CAPACITY))
                              : r_dropping;
        left_now   = starting ? i_block_len : r_block_left;
        left_after = left_now - BLEN_W'(1);
        do_write   = !drop && (r_fill < FW'(CAPACITY));
    end

    // Clamp the burst limit and size the pop
    always_comb begin
        pmax_c = i_pop_max;
        if (i_pop_max == '0) begin
            pmax_c = PMAX_W'(1);
        end else if (i_pop_max > PMAX_W'(MAX_BURST)) begin
            pmax_c = PMAX_W'(MAX_BURST);
        end
        fill_cw = CW'(r_fill);
        pmax_cw = CW'(pmax_c);
        pop_n   = (fill_cw < pmax_cw) ? BW'(fill_cw) : BW'(pmax_cw);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_req_type && (r_fill != '0)) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (xfer && (r_xfer_left == BW'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates per request
    always_comb begin
        n_fill       = r_fill;
        n_block_left = r_block_left;
        n_dropping   = r_dropping;
        n_issue_left = r_issue_left;
        n_xfer_left  = r_xfer_left;
        load_res     = 1'b0;
        res_status   = STAT_DATA;
        res_fill     = r_fill;
        store_req    = '0;

        if (in_acc && !i_req_type) begin
            if (starting && (i_block_len == '0)) begin
                n_dropping = 1'b0;
                load_res   = 1'b1;
                res_status = STAT_REJECT;
            end else begin
                if (do_write) begin
                    store_req.wr_en   = 1'b1;
                    store_req.wr_data = i_push_byte;
                    n_fill            = r_fill + FW'(1);
                end
                n_block_left = left_after;
                n_dropping   = drop;
                if (left_after == '0) begin
                    n_dropping = 1'b0;
                    load_res   = 1'b1;
                    res_status = drop ? STAT_REJECT : STAT_ACCEPT;
                    res_fill   = n_fill;
                end
            end
        end else if (in_acc && i_req_type) begin
            if (r_fill == '0) begin
                load_res   = 1'b1;
                res_status = STAT_EMPTY;
            end else begin
                n_issue_left = pop_n;
                n_xfer_left  = pop_n;
            end
        end

        if (issue) begin
            store_req.rd_en = 1'b1;
            n_issue_left    = r_issue_left - BW'(1);
        end
        if (xfer) begin
            n_fill      = r_fill - FW'(1);
            n_xfer_left = r_xfer_left - BW'(1);
        end
    end

    // Pending read flag
    always_comb begin
        n_rd_pend = r_rd_pend;
        if (issue) begin
            n_rd_pend = 1'b1;
        end else if (xfer) begin
            n_rd_pend = 1'b0;
        end
    end

    // Result register: load a status result or a popped byte, drop when taken
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_occ    = r_out_occ;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (load_res) begin
            n_out_valid  = 1'b1;
            n_out_byte   = '0;
            n_out_status = res_status;
            n_out_last   = 1'b1;
            n_out_occ    = OCC_W'(res_fill);
        end else if (xfer) begin
            n_out_valid  = 1'b1;
            n_out_byte   = rd_data;
            n_out_status = STAT_DATA;
            n_out_last   = (r_xfer_left == BW'(1));
            n_out_occ    = OCC_W'(n_fill);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_block_left <= '0;
            r_dropping   <= 1'b0;
            r_issue_left <= '0;
            r_xfer_left  <= '0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_block_left <= n_block_left;
            r_dropping   <= n_dropping;
            r_issue_left <= n_issue_left;
            r_xfer_left  <= n_xfer_left;
            r_rd_pend    <= n_rd_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_occ    <= n_out_occ;
    end

    assign o_valid     = r_out_valid;
    assign o_pop_byte  = r_out_byte;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;
    assign o_occupancy = r_out_occ;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(CAPACITY))
        else $error("fill level above capacity");

    a_issue_le_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue_left <= r_xfer_left)
        else $error("more reads left than transfers");

    a_last_ends_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_DATA) && o_last |-> (r_state == S_IDLE))
        else $error("burst still running after its last byte");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_EMPTY) |-> (o_occupancy == '0))
        else $error("empty status with nonzero occupancy");

    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rd_pend && (r_issue_left == '0))
        else $error("read activity outside a burst");
`endif

endmodule

/* dv/brfbp_tb_pkg.sv */
// Request codes shared by the byte FIFO testbench files.
// No dependencies.
`timescale 1ns / 1ps

package brfbp_tb_pkg;

    // Request type codes on i_req_type
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

endpackage

/* dv/brfbp_fifo_checker.sv */
// Shadow FIFO and result comparator for byte_ring_fifo_block_push_unit.
// Depends on brfbp_pkg and brfbp_tb_pkg.
`timescale 1ns / 1ps

module brfbp_fifo_checker
    import brfbp_pkg::*;
    import brfbp_tb_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int MAX_BURST = DEF_MAX_BURST
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic              i_req_type,
    input  logic [BYTE_W-1:0] i_push_byte,
    input  logic [BLEN_W-1:0] i_block_len,
    input  logic [PMAX_W-1:0] i_pop_max,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [BYTE_W-1:0] i_pop_byte,
    input  logic [STAT_W-1:0] i_status,
    input  logic              i_last,
    input  logic [OCC_W-1:0]  i_occupancy,
    output int                o_mismatches,
    output int                o_results_due
);

    typedef struct packed {
        logic [BYTE_W-1:0] pop_byte;
        t_status           status;
        logic              last;
        logic [OCC_W-1:0]  occupancy;
    } t_fifo_result;

    t_fifo_result      due_results[$];
    logic [BYTE_W-1:0] shadow_bytes [CAPACITY];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    int unsigned       fill_lvl;
    int unsigned       bytes_left;
    logic              drop_block;

    // Print one line per mismatch and count every one
    task automatic report_mismatch(input string msg);
        $display("[%0t] fifo check: %s", $time, msg);
        o_mismatches++;
    endtask

    // Queue one expected result, stamped with the current fill level
    function automatic void add_result(input logic [BYTE_W-1:0] data, input t_status st,
                                       input logic fin);
        t_fifo_result r;
        r.pop_byte  = data;
        r.status    = st;
        r.last      = fin;
        r.occupancy = OCC_W'(fill_lvl);
        due_results.push_back(r);
    endfunction

    // Advance the shadow FIFO by one accepted request
    function automatic void predict_request(input logic rt, input logic [BYTE_W-1:0] data,
                                            input logic [BLEN_W-1:0] blen,
                                            input logic [PMAX_W-1:0] pmax);
        int unsigned burst;
        int unsigned idx;
        logic [BYTE_W-1:0] rd_byte;
        if (rt == REQ_PUSH) begin
            // first byte of a block decides keep or drop for the whole block
            if (bytes_left == 0) begin
                if (blen == '0) begin
                    drop_block = 1'b0;
                    add_result('0, STAT_REJECT, 1'b1);
                    return;
                end
                drop_block = (fill_lvl + blen > CAPACITY);
                bytes_left = blen;
            end
            if (!drop_block && fill_lvl < CAPACITY) begin
                shadow_bytes[wr_ptr] = data;
                wr_ptr = (wr_ptr + 1) % CAPACITY;
                fill_lvl++;
            end
            bytes_left--;
            if (bytes_left == 0) begin
                add_result('0, drop_block ? STAT_REJECT : STAT_ACCEPT, 1'b1);
                drop_block = 1'b0;
            end
        end else if (fill_lvl == 0) begin
            add_result('0, STAT_EMPTY, 1'b1);
        end else begin
            // clamp the burst to 1..MAX_BURST, then to what is held
            burst = (pmax == '0) ? 1 : pmax;
            if (burst > MAX_BURST) burst = MAX_BURST;
            if (burst > fill_lvl) burst = fill_lvl;
            for (idx = 0; idx < burst; idx++) begin
                rd_byte = shadow_bytes[rd_ptr];
                rd_ptr = (rd_ptr + 1) % CAPACITY;
                fill_lvl--;
                add_result(rd_byte, STAT_DATA, idx + 1 == burst);
            end
        end
    endfunction

    // Watch both channels at the clock edge: predict, then compare
    always @(posedge i_clk) begin : watch
        t_fifo_result want;
        if (!i_rst_n) begin
            due_results.delete();
            wr_ptr       = 0;
            rd_ptr       = 0;
            fill_lvl     = 0;
            bytes_left   = 0;
            drop_block   = 1'b0;
            o_mismatches = 0;
        end else begin
            if (i_req_valid && i_req_ready) begin
                predict_request(i_req_type, i_push_byte, i_block_len, i_pop_max);
            end
            if (i_res_valid && i_res_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d byte %02h",
                                              i_status, i_pop_byte));
                end else begin
                    want = due_results.pop_front();
                    if (i_pop_byte !== want.pop_byte)
                        report_mismatch($sformatf("pop_byte %02h expected %02h",
                                                  i_pop_byte, want.pop_byte));
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d expected %0d",
                                                  i_status, want.status));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last %0b expected %0b",
                                                  i_last, want.last));
                    if (i_occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy %0d expected %0d",
                                                  i_occupancy, want.occupancy));
                end
            end
        end
        o_results_due = due_results.size();
    end

endmodule

/* dv/tb_byte_ring_fifo_block_push_unit.sv */
// Testbench top for byte_ring_fifo_block_push_unit: drives push blocks and pop
// bursts, random stalls on both sides, verdict from brfbp_fifo_checker.
// Depends on brfbp_pkg, brfbp_tb_pkg and brfbp_fifo_checker.
`timescale 1ns / 1ps

module tb_byte_ring_fifo_block_push_unit;
    import brfbp_pkg::*;
    import brfbp_tb_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int MAX_BURST    = DEF_MAX_BURST;
    localparam int RAND_ITEMS   = 300;
    localparam int QUIET_ITEMS  = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int STUCK_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 100;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              i_req_type  = REQ_PUSH;
    logic [BYTE_W-1:0] i_push_byte = '0;
    logic [BLEN_W-1:0] i_block_len = '0;
    logic [PMAX_W-1:0] i_pop_max   = '0;
    logic              i_ready     = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [BYTE_W-1:0] o_pop_byte;
    logic [STAT_W-1:0] o_status;
    logic              o_last;
    logic [OCC_W-1:0]  o_occupancy;

    int   mismatches;
    int   results_due;
    int   gap_pct  = 10;
    logic quiet    = 1'b0;
    logic hold_req = 1'b0;
    int   stuck_cycles = 0;

    byte_ring_fifo_block_push_unit #(
        .CAPACITY  (CAPACITY),
        .MAX_BURST (MAX_BURST)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_push_byte (i_push_byte),
        .i_block_len (i_block_len),
        .i_pop_max   (i_pop_max),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pop_byte  (o_pop_byte),
        .o_status    (o_status),
        .o_last      (o_last),
        .o_occupancy (o_occupancy)
    );

    brfbp_fifo_checker #(
        .CAPACITY  (CAPACITY),
        .MAX_BURST (MAX_BURST)
    ) u_fifo_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_req_type    (i_req_type),
        .i_push_byte   (i_push_byte),
        .i_block_len   (i_block_len),
        .i_pop_max     (i_pop_max),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_pop_byte    (o_pop_byte),
        .i_status      (o_status),
        .i_last        (o_last),
        .i_occupancy   (o_occupancy),
        .o_mismatches  (mismatches),
        .o_results_due (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // End the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Result side: random stall bursts, one long hold on request, none when quiet
    initial begin : result_sink
        int   stall;
        int   stall_pct;
        logic held;
        stall_pct = 10;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                stall = $urandom_range(1, 12);
                i_ready <= 1'b0;
                repeat (stall - 1) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 63) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 8;
                        default: stall_pct = 30;
                    endcase
                end
            end
        end
    end

    function automatic logic [PMAX_W-1:0] rand_pop_limit();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return PMAX_W'($urandom_range(MAX_BURST + 1, 127));
        return PMAX_W'($urandom_range(1, MAX_BURST));
    endfunction

    // Offer one request, with an optional gap first; return once it will be taken
    task automatic send_item(input logic rt, input logic [BYTE_W-1:0] data,
                             input logic [BLEN_W-1:0] blen, input logic [PMAX_W-1:0] pmax);
        int gap;
        @(posedge i_clk);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= rt;
        i_push_byte <= data;
        i_block_len <= blen;
        i_pop_max   <= pmax;
        do @(negedge i_clk); while (!o_ready);
    endtask

    task automatic send_push(input logic [BYTE_W-1:0] data, input logic [BLEN_W-1:0] blen);
        send_item(REQ_PUSH, data, blen, rand_pop_limit());
    endtask

    task automatic send_pop(input logic [PMAX_W-1:0] pmax);
        send_item(REQ_POP, BYTE_W'($urandom), BLEN_W'($urandom_range(0, 2047)), pmax);
    endtask

    // Push a whole block; pops may cut in between its bytes
    task automatic send_block(input int len, input int pop_pct, output int n_items);
        int idx;
        n_items = 0;
        for (idx = 0; idx < len; idx++) begin
            if (idx > 0 && $urandom_range(0, 99) < pop_pct) begin
                send_pop(rand_pop_limit());
                n_items++;
            end
            send_push(BYTE_W'($urandom),
                      (idx == 0) ? BLEN_W'(len) : BLEN_W'($urandom_range(0, 2047)));
            n_items++;
        end
    endtask

    // Stop offering and wait until every expected result has come out
    task automatic wait_drained();
        @(posedge i_clk);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (results_due != 0);
    endtask

    initial begin : stimulus
        int sent;
        int n;
        int len;
        int scen;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pops, zero-length and single-byte blocks, pop mid-block
        send_pop(7'd5);
        send_push(8'hFF, 11'd0);
        send_push(8'h00, 11'd1);
        send_push(8'hFF, 11'd3);
        send_pop(7'd0);
        send_push(8'hA5, 11'h7FF);
        send_push(8'h5A, 11'd0);
        send_pop(7'd127);
        send_pop(7'd64);
        send_block(4, 0, n);
        send_pop(7'd64);
        send_pop(7'd1);
        send_block(2, 0, n);
        send_pop(7'd2);

        // Push and pop against a held result side
        wait_drained();
        hold_req = 1'b1;
        send_push(8'h3C, 11'd1);
        repeat (3) send_pop(7'd64);
        send_block(2 * MAX_BURST, 0, n);
        repeat (3) send_pop(7'd64);
        send_pop(7'd64);

        // Random: mostly well-formed blocks and pops, some broken requests
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent >= RAND_ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    default: gap_pct = 40;
                endcase
            end
            scen = $urandom_range(0, 99);
            if (scen < 50) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
                                                  : $urandom_range(1, 24);
                send_block(len, 10, n);
                sent += n;
            end else if (scen < 82) begin
                send_pop(rand_pop_limit());
                sent++;
            end else if (scen < 88) begin
                send_push(BYTE_W'($urandom), 11'd0);
                sent++;
            end else if (scen < 96) begin
                send_block($urandom_range(2, 16), 50, n);
                sent += n;
            end else if (!quiet) begin
                wait_drained();
            end
        end

        // Drain, let stray results show, then judge
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* byte_ring_fifo_block_push_unit.f */
design/brfbp_pkg.sv
design/brfbp_store.sv
design/byte_ring_fifo_block_push_unit.sv
dv/brfbp_tb_pkg.sv
dv/brfbp_fifo_checker.sv
dv/tb_byte_ring_fifo_block_push_unit.sv
